// File: hdl/hkr_pkg.sv
package hkr_pkg;

  // Fixed field widths
  localparam int POS_W  = 32;
  localparam int STEP_W = 17;

  // Phase step after reset: 1.0 at the default fraction width
  localparam logic [STEP_W-1:0] STEP_RESET = 17'h10000;

  // Default phase fraction width
  localparam int PHASE_FRAC_BITS_DEF = 16;

  // At most this many interpolated samples per keyframe
  localparam int SAMPLE_CAP = 63;
  localparam int CNT_W      = 6;

  // Saturation limits
  localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MGO,
    S_MWAIT,
    S_EMIT,
    S_ENDPT
  } seq_state_t;

  // Multiply-accumulate passes of one sample
  typedef enum logic [2:0] {
    OP_T2,
    OP_T3,
    OP_P0,
    OP_P1,
    OP_S0,
    OP_S1
  } mac_op_t;

  // Command to the serial MAC
  typedef struct packed {
    logic go;
    logic clear;
  } mac_cmd_t;

  // Status from the serial MAC
  typedef struct packed {
    logic busy;
    logic done;
  } mac_sts_t;

  // One result item
  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic                    last;
  } res_t;

endpackage

// File: hdl/hermite_keyframe_resampler_top.sv
// Each interpolated sample is computed by the bit-serial multiply-accumulate unit
// in six passes of PHASE_FRAC_BITS+3 multiplier bits each. One keyframe is taken
// at a time: in_stall stays high until all of its frames have been handed out.
// Reset: synchronous active-low rst_n clears the track state and sets phase_step
// to 1.0; keyframes are taken from the first clock edge with rst_n high.
module hermite_keyframe_resampler_top #(
  parameter int PHASE_FRAC_BITS = hkr_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [hkr_pkg::STEP_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [31:0]         in_key_position,
  input  logic signed [31:0]         in_key_slope,
  input  logic                       in_track_start,
  input  logic                       in_track_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [31:0]         out_frame_position,
  output logic                       out_last_of_run
);
  import hkr_pkg::*;

  logic [STEP_W-1:0]               phase_step_r;
  mac_cmd_t                        mac_cmd;
  mac_sts_t                        mac_sts;
  logic signed [31:0]              mac_mcand;
  logic signed [PHASE_FRAC_BITS+2:0]  mac_mplier;
  logic signed [PHASE_FRAC_BITS+36:0] mac_acc;
  logic                            res_valid;
  res_t                            res;
  logic                            res_take;
  logic                            out_valid_r;
  logic signed [POS_W-1:0]         out_pos_r;
  logic                            out_last_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= STEP_RESET;
    end else if (cfg_wr_en) begin
      phase_step_r <= cfg_wr_data;
    end
  end

  hkr_seq #(
    .FRAC_BITS (PHASE_FRAC_BITS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .key_position (in_key_position),
    .key_slope    (in_key_slope),
    .track_start  (in_track_start),
    .track_end    (in_track_end),
    .phase_step   (phase_step_r),
    .mac_cmd      (mac_cmd),
    .mac_mcand    (mac_mcand),
    .mac_mplier   (mac_mplier),
    .mac_sts      (mac_sts),
    .mac_acc      (mac_acc),
    .res_valid    (res_valid),
    .res          (res),
    .res_take     (res_take)
  );

  hkr_serial_mac #(
    .FRAC_BITS (PHASE_FRAC_BITS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (mac_cmd),
    .mcand  (mac_mcand),
    .mplier (mac_mplier),
    .sts    (mac_sts),
    .acc    (mac_acc)
  );

  // Output register: a result moves in when the slot is empty or being drained
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_pos_r  <= res.pos;
      out_last_r <= res.last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_position = out_pos_r;
  assign out_last_of_run    = out_last_r;

`ifndef SYNTH
  // No result pending from the sequencer while new keyframes are taken
  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !res_valid)
    else $error("result pending while input open");

  // A lone start+end keyframe offers its own position as the end sample
  a_single_key: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_track_start && in_track_end) |=>
      (res_valid && res.last && (res.pos == $past(in_key_position))))
    else $error("single keyframe end sample missing");

  // The MAC only runs while a keyframe is in progress
  a_mac_in_item: assert property (@(posedge clk) disable iff (!rst_n)
    mac_sts.busy |-> in_stall)
    else $error("MAC busy with input open");

  // A taken result shows up in the output register
  a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> (out_valid && (out_frame_position == $past(res.pos))))
    else $error("result transfer lost");
`endif

endmodule

// File: hdl/hkr_serial_mac.sv
module hkr_serial_mac #(
  parameter int FRAC_BITS = hkr_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hkr_pkg::mac_cmd_t          cmd,
  input  logic signed [31:0]         mcand,
  input  logic signed [FRAC_BITS+2:0] mplier,
  output hkr_pkg::mac_sts_t          sts,
  output logic signed [FRAC_BITS+36:0] acc
);
  import hkr_pkg::*;

  localparam int BW    = FRAC_BITS + 3;
  localparam int ACC_W = FRAC_BITS + 37;
  localparam int BC_W  = $clog2(BW);
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (FRAC_BITS - 1);

  logic signed [ACC_W-1:0] a_r;
  logic        [BW-1:0]    b_r;
  logic        [BC_W-1:0]  cnt_r;
  logic                    busy_r;
  logic                    done_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic                    step_last;

  // Multiplier bits are consumed LSB first; the top bit carries negative weight
  assign step_last = (cnt_r == BC_W'(BW - 1));

  always_comb begin
    acc_nxt = acc_r;
    if (b_r[0]) begin
      acc_nxt = step_last ? (acc_r - a_r) : (acc_r + a_r);
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && step_last;
      if (cmd.go) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_last) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Shift registers and accumulator
  always_ff @(posedge clk) begin
    if (cmd.go) begin
      a_r   <= {{(ACC_W-32){mcand[31]}}, mcand};
      b_r   <= mplier;
      cnt_r <= '0;
      if (cmd.clear) begin
        acc_r <= ACC_HALF;
      end
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      a_r   <= a_r <<< 1;
      b_r   <= b_r >> 1;
      cnt_r <= cnt_r + BC_W'(1);
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign acc      = acc_r;

endmodule

// File: hdl/hkr_seq.sv
module hkr_seq #(
  parameter int FRAC_BITS = hkr_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            key_position,
  input  logic signed [31:0]            key_slope,
  input  logic                          track_start,
  input  logic                          track_end,
  input  logic [hkr_pkg::STEP_W-1:0]    phase_step,
  output hkr_pkg::mac_cmd_t             mac_cmd,
  output logic signed [31:0]            mac_mcand,
  output logic signed [FRAC_BITS+2:0]   mac_mplier,
  input  hkr_pkg::mac_sts_t             mac_sts,
  input  logic signed [FRAC_BITS+36:0]  mac_acc,
  output logic                          res_valid,
  output hkr_pkg::res_t                 res,
  input  logic                          res_take
);
  import hkr_pkg::*;

  localparam int BW    = FRAC_BITS + 3;
  localparam int CW    = FRAC_BITS + 4;
  localparam int ACC_W = FRAC_BITS + 37;
  localparam int QW    = ACC_W - FRAC_BITS;
  localparam int UW    = ((FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W) + 1;
  localparam logic [UW-1:0] U_ONE = UW'(1) << FRAC_BITS;

  seq_state_t state_r, state_nxt;
  mac_op_t    op_r, op_nxt;

  logic signed [POS_W-1:0] key_pos_r, key_pos_nxt;
  logic signed [POS_W-1:0] key_slope_r, key_slope_nxt;
  logic                    end_r, end_nxt;
  logic signed [POS_W-1:0] prev_pos_r, prev_pos_nxt;
  logic signed [POS_W-1:0] prev_slope_r, prev_slope_nxt;
  logic                    have_prev_r, have_prev_nxt;
  logic [STEP_W-1:0]       seg_phase_r, seg_phase_nxt;
  logic [UW-1:0]           u_r, u_nxt;
  logic [CNT_W-1:0]        n_r, n_nxt;
  logic [FRAC_BITS-1:0]    t2_r, t2_nxt;
  logic [FRAC_BITS-1:0]    t3_r, t3_nxt;

  logic [FRAC_BITS-1:0]    t_val;
  logic [FRAC_BITS-1:0]    frac_hi;
  logic [UW-1:0]           u_step;
  logic                    more_samples;
  logic                    last_sample;
  logic signed [CW-1:0]    t2x, t3x, tx, onex;
  logic signed [CW-1:0]    h00x, h01x, h10x, h11x;
  logic signed [QW-1:0]    q;
  logic [QW-POS_W:0]       q_hi;
  logic signed [POS_W-1:0] sample;

  assign t_val   = u_r[FRAC_BITS-1:0];
  assign frac_hi = mac_acc[FRAC_BITS +: FRAC_BITS];
  assign u_step  = u_r + UW'(phase_step);

  assign more_samples = (u_r < U_ONE) && (n_r < CNT_W'(SAMPLE_CAP));
  assign last_sample  = !end_r && ((u_step >= U_ONE) || (n_r == CNT_W'(SAMPLE_CAP - 1)));

  // Hermite basis weights from t, t^2, t^3
  always_comb begin
    t2x  = CW'(t2_r);
    t3x  = CW'(t3_r);
    tx   = CW'(t_val);
    onex = CW'(1) << FRAC_BITS;
    h00x = (t3x <<< 1) - (t2x <<< 1) - t2x + onex;
    h01x = (t2x <<< 1) + t2x - (t3x <<< 1);
    h10x = t3x - (t2x <<< 1) + tx;
    h11x = t3x - t2x;
  end

  // Round-half-up already in the accumulator; floor shift and saturate
  always_comb begin
    q    = mac_acc[ACC_W-1:FRAC_BITS];
    q_hi = q[QW-1:POS_W-1];
    if ((&q_hi) || !(|q_hi)) begin
      sample = q[POS_W-1:0];
    end else begin
      sample = q[QW-1] ? POS_MIN : POS_MAX;
    end
  end

  // Operand select for the current MAC pass
  always_comb begin
    unique case (op_r)
      OP_T2: begin
        mac_mcand  = POS_W'(t_val);
        mac_mplier = BW'(t_val);
      end
      OP_T3: begin
        mac_mcand  = POS_W'(t2_r);
        mac_mplier = BW'(t_val);
      end
      OP_P0: begin
        mac_mcand  = prev_pos_r;
        mac_mplier = h00x[BW-1:0];
      end
      OP_P1: begin
        mac_mcand  = key_pos_r;
        mac_mplier = h01x[BW-1:0];
      end
      OP_S0: begin
        mac_mcand  = prev_slope_r;
        mac_mplier = h10x[BW-1:0];
      end
      OP_S1: begin
        mac_mcand  = key_slope_r;
        mac_mplier = h11x[BW-1:0];
      end
      default: begin
        mac_mcand  = '0;
        mac_mplier = '0;
      end
    endcase
  end

  assign mac_cmd.go    = (state_r == S_MGO);
  assign mac_cmd.clear = (op_r == OP_T2) || (op_r == OP_T3) || (op_r == OP_P0);
  assign in_stall      = (state_r != S_IDLE);

  // Next state and result
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_pos_nxt    = key_pos_r;
    key_slope_nxt  = key_slope_r;
    end_nxt        = end_r;
    prev_pos_nxt   = prev_pos_r;
    prev_slope_nxt = prev_slope_r;
    have_prev_nxt  = have_prev_r;
    seg_phase_nxt  = seg_phase_r;
    u_nxt          = u_r;
    n_nxt          = n_r;
    t2_nxt         = t2_r;
    t3_nxt         = t3_r;
    res_valid      = 1'b0;
    res.pos        = sample;
    res.last       = last_sample;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_pos_nxt   = key_position;
          key_slope_nxt = key_slope;
          end_nxt       = track_end;
          if (track_start || !have_prev_r) begin
            seg_phase_nxt = '0;
            if (track_end) begin
              have_prev_nxt = 1'b0;
              state_nxt     = S_ENDPT;
            end else begin
              prev_pos_nxt   = key_position;
              prev_slope_nxt = key_slope;
              have_prev_nxt  = 1'b1;
            end
          end else begin
            u_nxt     = UW'(seg_phase_r);
            n_nxt     = '0;
            state_nxt = S_CHECK;
          end
        end
      end

      S_CHECK: begin
        if (more_samples) begin
          op_nxt    = OP_T2;
          state_nxt = S_MGO;
        end else if (end_r) begin
          have_prev_nxt = 1'b0;
          seg_phase_nxt = '0;
          state_nxt     = S_ENDPT;
        end else begin
          // carry the overshoot into the next segment
          seg_phase_nxt  = (u_r >= U_ONE) ? STEP_W'(u_r - U_ONE) : '0;
          prev_pos_nxt   = key_pos_r;
          prev_slope_nxt = key_slope_r;
          state_nxt      = S_IDLE;
        end
      end

      S_MGO: begin
        state_nxt = S_MWAIT;
      end

      S_MWAIT: begin
        if (mac_sts.done) begin
          state_nxt = S_MGO;
          unique case (op_r)
            OP_T2: begin
              t2_nxt = frac_hi;
              op_nxt = OP_T3;
            end
            OP_T3: begin
              t3_nxt = frac_hi;
              op_nxt = OP_P0;
            end
            OP_P0: op_nxt = OP_P1;
            OP_P1: op_nxt = OP_S0;
            OP_S0: op_nxt = OP_S1;
            OP_S1: state_nxt = S_EMIT;
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_EMIT: begin
        res_valid = 1'b1;
        if (res_take) begin
          u_nxt     = u_step;
          n_nxt     = n_r + CNT_W'(1);
          state_nxt = S_CHECK;
        end
      end

      S_ENDPT: begin
        res_valid = 1'b1;
        res.pos   = key_pos_r;
        res.last  = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      have_prev_r <= 1'b0;
      seg_phase_r <= '0;
    end else begin
      state_r     <= state_nxt;
      have_prev_r <= have_prev_nxt;
      seg_phase_r <= seg_phase_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_pos_r    <= key_pos_nxt;
    key_slope_r  <= key_slope_nxt;
    end_r        <= end_nxt;
    prev_pos_r   <= prev_pos_nxt;
    prev_slope_r <= prev_slope_nxt;
    u_r          <= u_nxt;
    n_r          <= n_nxt;
    t2_r         <= t2_nxt;
    t3_r         <= t3_nxt;
  end

endmodule

// File: sim/hkr_frame_checker.sv
`timescale 1ns / 1ps

module hkr_frame_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [hkr_pkg::STEP_W-1:0]       cfg_wr_data,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic signed [hkr_pkg::POS_W-1:0] in_key_position,
  input  logic signed [hkr_pkg::POS_W-1:0] in_key_slope,
  input  logic                             in_track_start,
  input  logic                             in_track_end,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic signed [hkr_pkg::POS_W-1:0] out_frame_position,
  input  logic                             out_last_of_run,
  output int                               mismatch_count,
  output int                               frames_pending
);
  import hkr_pkg::*;

  localparam int     FRAC      = PHASE_FRAC_BITS_DEF;
  localparam longint PHASE_ONE = longint'(1) << FRAC;
  localparam longint HALF_LSB  = PHASE_ONE >> 1;

  // Track state as the block should hold it
  logic [STEP_W-1:0]       phase_step_q = STEP_RESET;
  logic signed [POS_W-1:0] held_pos     = '0;
  logic signed [POS_W-1:0] held_slope   = '0;
  longint                  seg_phase    = 0;
  logic                    track_open   = 1'b0;

  // Frames still owed by the block, oldest first
  res_t expected_frames[$];

  initial begin
    mismatch_count = 0;
    frames_pending = 0;
  end

  // One Hermite sample at phase t, rounded and clipped to Q16.16
  function automatic logic signed [POS_W-1:0] hermite_at(longint p0, longint p1,
                                                          longint s0, longint s1,
                                                          longint t);
    longint t2, t3, h00, h01, h10, h11, acc, r;
    t2  = (t * t + HALF_LSB) >>> FRAC;
    t3  = (t2 * t + HALF_LSB) >>> FRAC;
    h00 = 2 * t3 - 3 * t2 + PHASE_ONE;
    h01 = 3 * t2 - 2 * t3;
    h10 = t3 - 2 * t2 + t;
    h11 = t3 - t2;
    acc = h00 * p0 + h01 * p1 + h10 * s0 + h11 * s1;
    // arithmetic shift floors, matching round half up
    r = (acc + HALF_LSB) >>> FRAC;
    if (r > longint'(POS_MAX)) r = longint'(POS_MAX);
    if (r < longint'(POS_MIN)) r = longint'(POS_MIN);
    return r[POS_W-1:0];
  endfunction

  // Queue the frames one keyframe transfer should cause and advance the track
  task automatic resample_key(logic signed [POS_W-1:0] pos, logic signed [POS_W-1:0] slope,
                              logic key_start, logic key_end);
    res_t   r;
    longint u;
    int     n;
    logic   more;
    if (key_start || !track_open) begin
      if (key_end) begin
        // lone keyframe: its position is the whole run
        r.pos  = pos;
        r.last = 1'b1;
        expected_frames.push_back(r);
        track_open = 1'b0;
      end else begin
        held_pos   = pos;
        held_slope = slope;
        track_open = 1'b1;
      end
      seg_phase = 0;
    end else begin
      u = seg_phase;
      n = 0;
      while (u < PHASE_ONE && n < SAMPLE_CAP) begin
        r.pos = hermite_at(held_pos, pos, held_slope, slope, u);
        n++;
        u += longint'(phase_step_q);
        more   = (u < PHASE_ONE) && (n < SAMPLE_CAP);
        r.last = !key_end && !more;
        expected_frames.push_back(r);
      end
      // overshoot carries on; a capped segment restarts at zero
      seg_phase = (u >= PHASE_ONE) ? u - PHASE_ONE : 0;
      if (key_end) begin
        r.pos  = pos;
        r.last = 1'b1;
        expected_frames.push_back(r);
        track_open = 1'b0;
        seg_phase  = 0;
      end else begin
        held_pos   = pos;
        held_slope = slope;
      end
    end
  endtask

  // Watch both channels at each rising edge
  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst_n) begin
      phase_step_q = STEP_RESET;
      held_pos     = '0;
      held_slope   = '0;
      seg_phase    = 0;
      track_open   = 1'b0;
      expected_frames.delete();
    end else begin
      // result transfer: compare against the oldest expectation
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_frames.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected frame, expected none, got position %0d last %0b",
                   $time, out_frame_position, out_last_of_run);
        end else begin
          want = expected_frames.pop_front();
          if (want.pos !== out_frame_position) begin
            mismatch_count++;
            $display("%0t: frame_position expected %0d, got %0d",
                     $time, want.pos, out_frame_position);
          end
          if (want.last !== out_last_of_run) begin
            mismatch_count++;
            $display("%0t: last_of_run expected %0b, got %0b",
                     $time, want.last, out_last_of_run);
          end
        end
      end
      if (cfg_wr_en === 1'b1) phase_step_q = cfg_wr_data;
      // keyframe transfer
      if (in_valid === 1'b1 && in_stall === 1'b0)
        resample_key(in_key_position, in_key_slope, in_track_start, in_track_end);
    end
    frames_pending = expected_frames.size();
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import hkr_pkg::*;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  localparam int FRAC = PHASE_FRAC_BITS_DEF;

  // Phase steps of interest
  localparam logic [STEP_W-1:0] STEP_UNITY   = 17'd65536;
  localparam logic [STEP_W-1:0] STEP_QUARTER = 17'd16384;
  localparam logic [STEP_W-1:0] STEP_MIN     = 17'd1041;
  localparam logic [STEP_W-1:0] STEP_CAPPED  = 17'd1000;   // too fine, hits the sample cap
  localparam logic [STEP_W-1:0] STEP_WIDE    = 17'h1FFFF;  // above 1.0, large carry

  localparam int N_PHASES      = 9;
  // one sample's worth of cycles plus margin
  localparam int SETTLE_CYCLES = 6 * FRAC + 32 + 64;
  // ~220 keyframes of up to 64 frames each, taken several times over
  localparam longint CYCLE_LIMIT = 64'd12_000_000;

  logic                    clk;
  logic                    rst_n              = 1'b0;
  logic                    cfg_wr_en          = 1'b0;
  logic [STEP_W-1:0]       cfg_wr_data        = '0;
  logic                    in_valid           = 1'b0;
  logic                    in_stall;
  logic signed [POS_W-1:0] in_key_position    = '0;
  logic signed [POS_W-1:0] in_key_slope       = '0;
  logic                    in_track_start     = 1'b0;
  logic                    in_track_end       = 1'b0;
  logic                    out_valid;
  logic                    out_stall          = 1'b0;
  logic signed [POS_W-1:0] out_frame_position;
  logic                    out_last_of_run;

  int     mismatch_count;
  int     frames_pending;
  int     tx_idle_pct  = 0;
  int     rx_stall_pct = 0;
  longint cycle_count  = 0;

  hermite_keyframe_resampler_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_key_position    (in_key_position),
    .in_key_slope       (in_key_slope),
    .in_track_start     (in_track_start),
    .in_track_end       (in_track_end),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_position (out_frame_position),
    .out_last_of_run    (out_last_of_run)
  );

  hkr_frame_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_key_position    (in_key_position),
    .in_key_slope       (in_key_slope),
    .in_track_start     (in_track_start),
    .in_track_end       (in_track_end),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_position (out_frame_position),
    .out_last_of_run    (out_last_of_run),
    .mismatch_count     (mismatch_count),
    .frames_pending     (frames_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  // Half moderate Q16.16 values, the rest rails and full-range noise
  function automatic logic signed [POS_W-1:0] pick_q16();
    logic signed [POS_W-1:0] v;
    v = $urandom;
    case ($urandom_range(7))
      0:       return POS_MAX;
      1:       return POS_MIN;
      2, 3:    return v;
      default: return v >>> $urandom_range(4, 16);
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] step_for_phase(int p);
    case (p)
      0:       return STEP_UNITY;
      1:       return STEP_W'($urandom_range(8192, 65535));
      2:       return STEP_MIN;
      3:       return STEP_W'($urandom_range(2048, 16384));
      4:       return STEP_WIDE;
      5:       return STEP_W'($urandom_range(20000, 65536));
      6:       return STEP_CAPPED;
      7:       return STEP_W'($urandom_range(8192, 40000));
      default: return STEP_W'($urandom_range(30000, 65536));
    endcase
  endfunction

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_SENDER:   begin tx_idle_pct = 62; rx_stall_pct = 0;  end
      IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct = 62; end
      IDLE_BOTH:     begin tx_idle_pct = 18; rx_stall_pct = 18; end
      default:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
    endcase
  endtask

  // One keyframe transfer; called and returns at a falling edge
  task automatic send_key(logic signed [POS_W-1:0] pos, logic signed [POS_W-1:0] slope,
                          logic key_start, logic key_end);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_key_position <= pos;
    in_key_slope    <= slope;
    in_track_start  <= key_start;
    in_track_end    <= key_end;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  // Wait until every owed frame is out and the block has gone quiet
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (frames_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_step(logic [STEP_W-1:0] step);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= step;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Start, middle keys, end; now and then the flags are scrambled
  task automatic send_track(int n_keys);
    logic ks, ke;
    for (int k = 0; k < n_keys; k++) begin
      ks = (k == 0);
      ke = (k == n_keys - 1);
      if ($urandom_range(99) < 12) begin
        ks = 1'($urandom_range(1));
        ke = 1'($urandom_range(1));
      end
      send_key(pick_q16(), pick_q16(), ks, ke);
    end
  endtask

  initial begin : stimulus
    logic [STEP_W-1:0] step;
    int                quota;
    int                sent;
    int                n_keys;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    set_idling(IDLE_NONE);

    // Reset step of 1.0: keyframe with no track held, lone keyframe, rails
    send_key(32'sh0064_0000, '0, 1'b0, 1'b0);
    send_key(-32'sh0005_0000, 32'sh0001_0000, 1'b1, 1'b1);
    send_key(POS_MAX, POS_MAX, 1'b1, 1'b0);
    send_key(POS_MIN, POS_MIN, 1'b0, 1'b1);

    // Quarter step: saturation both ways, restart inside a track
    settle_idle();
    write_step(STEP_QUARTER);
    send_key(32'sh7FFF_0000, POS_MAX, 1'b1, 1'b0);
    send_key(POS_MAX, POS_MAX, 1'b0, 1'b0);
    send_key(POS_MIN, POS_MIN, 1'b0, 1'b0);
    send_key('0, POS_MIN, 1'b0, 1'b0);
    send_key('0, '0, 1'b0, 1'b1);
    send_key(32'sh0003_8000, -32'sh0000_4000, 1'b1, 1'b1);
    send_key(32'sh0000_0001, -32'sh0000_0001, 1'b1, 1'b0);
    send_key(32'sh0000_0002, 32'sh0000_0003, 1'b1, 1'b0);
    send_key(-32'sh0000_0001, 32'sh0000_0001, 1'b0, 1'b1);

    // Step too fine: sample cap stops the segment, then cap plus end frame
    settle_idle();
    write_step(STEP_CAPPED);
    send_key(32'sh0010_0000, 32'sh0020_0000, 1'b1, 1'b0);
    send_key(-32'sh0010_0000, -32'sh0008_0000, 1'b0, 1'b0);
    send_key(32'sh0004_0000, 32'sh0002_0000, 1'b0, 1'b1);

    // Step above 1.0: carry past one gives a segment with no frames
    settle_idle();
    write_step(STEP_WIDE);
    send_key(32'sh0001_0000, 32'sh0001_0000, 1'b1, 1'b0);
    send_key(32'sh0002_0000, -32'sh0001_0000, 1'b0, 1'b0);
    send_key(32'sh0003_0000, 32'sh0004_0000, 1'b0, 1'b0);
    send_key(32'sh0004_0000, '0, 1'b0, 1'b0);
    send_key(32'sh0005_0000, 32'sh0001_0000, 1'b0, 1'b1);

    // Finest legal step
    settle_idle();
    write_step(STEP_MIN);
    send_key(-32'sh0020_0000, 32'sh0040_0000, 1'b1, 1'b0);
    send_key(32'sh0020_0000, -32'sh0040_0000, 1'b0, 1'b1);

    // Random tracks, a new step and idling pattern per phase
    for (int p = 0; p < N_PHASES; p++) begin
      step = step_for_phase(p);
      settle_idle();
      write_step(step);
      set_idling(idle_mode_t'(p % 4));
      quota = (step < 17'd8192) ? 10 : 25;
      sent  = 0;
      while (sent < quota) begin
        n_keys = $urandom_range(1, 6);
        if (n_keys > quota - sent) n_keys = quota - sent;
        send_track(n_keys);
        sent += n_keys;
      end
    end

    settle_idle();
    if (mismatch_count == 0 && frames_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
